>>> rtl/ffra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffra_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OOM        = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  // Request opcodes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_POOL_BASE   = 1'b0,
    CFG_POOL_LENGTH = 1'b1
  } cfg_idx_e;

  // Per-cell command.
  typedef enum logic [2:0] {
    C_HOLD,
    C_TAKE_L,
    C_TAKE_R,
    C_LOAD,
    C_ADD_R,
    C_CLEAR
  } cell_cmd_e;

  // Whole-table command.
  typedef enum logic [2:0] {
    T_NONE,
    T_REMOVE,
    T_INSERT,
    T_MERGE,
    T_INIT,
    T_CLEAR
  } tbl_op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_REMOVE,
    S_FPLACE,
    S_FINSERT,
    S_UPLACE,
    S_UINSERT,
    S_MERGE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    logic fit;
    logic match;
    logic lt;
    logic gt;
    logic adj;
  } cell_flags_t;

  typedef struct packed {
    tbl_op_e     op;
    logic [31:0] start;
    logic [31:0] size;
  } tbl_cmd_t;

endpackage
`default_nettype wire

>>> rtl/ffra_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ffra_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] req_size;
  logic [31:0] free_base;

  modport source (output valid, op, req_size, free_base, input ready);
  modport sink (input valid, op, req_size, free_base, output ready);
endinterface
`default_nettype wire

>>> rtl/ffra_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ffra_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] alloc_addr;
  logic [1:0]  status;

  modport source (output valid, alloc_addr, status, input ready);
  modport sink (input valid, alloc_addr, status, output ready);
endinterface
`default_nettype wire

>>> rtl/first_fit_region_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Payload
// req      in         op, req_size, free_base
// rsp      out        alloc_addr, status
// cfg_*    in         pool_base (index 0), pool_length (index 1)
//
// A transaction is accepted, then each scan visits the entries in turn, followed by the remove
// and insert steps, the merge steps and finally the loading of the result.
// Reset and a configuration write taken while idle leave one free region covering the pool.
// A result waits in the output register; a new request is taken meanwhile, and its
// own result holds in the last step until the register is handed over.
module first_fit_region_allocator import ffra_pkg::*; #(
  parameter int FREE_ENTRIES = 16,
  parameter int USED_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  ffra_req_if.sink         req,
  ffra_rsp_if.source       rsp
);

  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int FIW = $clog2(FREE_ENTRIES);
  localparam int UCW = $clog2(USED_ENTRIES + 1);
  localparam int UIW = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;

  state_e state_q, state_d;

  logic           op_q;
  logic [31:0]    req_q, fb_q, b_q, nb_q, nl_q;
  logic [FCW-1:0] fi_q, nf_q;
  logic [UCW-1:0] ui_q, nu_q;
  logic [31:0]    pool_base_q, pool_len_q;
  status_e        status_q;
  logic           out_valid_q;
  logic [31:0]    out_addr_q;
  status_e        out_status_q;

  tbl_cmd_t fcmd, ucmd;
  entry_t   frd;
  logic [FREE_ENTRIES-1:0] f_fit, f_lt, f_gt, f_adj;
  logic [USED_ENTRIES-1:0] u_match, u_lt, u_gt;
  logic [31:0] f_key, u_key;
  logic [31:0] cfg_base, cfg_len;
  logic cfg_hit, in_ready, done_go;

  logic f_end, u_end, f_place, u_place, merge_more;

  assign cfg_hit  = cfg_we_i;
  assign cfg_base = (cfg_idx_i == CFG_POOL_BASE) ? cfg_wdata_i : pool_base_q;
  assign cfg_len  = (cfg_idx_i == CFG_POOL_LENGTH) ? cfg_wdata_i : pool_len_q;

  assign f_key = (op_q == OP_FREE) ? fb_q : nb_q;
  assign u_key = (op_q == OP_FREE) ? fb_q : b_q;

  // Scan conditions at the current index.
  assign f_end = fi_q >= nf_q;
  assign u_end = ui_q >= nu_q;
  assign f_place = f_end || ((fi_q == '0) ? f_gt[0] : !f_lt[fi_q[FIW-1:0]]);
  assign u_place = u_end || ((ui_q == '0) ? u_gt[0] : !u_lt[ui_q[UIW-1:0]]);
  assign merge_more = ({1'b0, fi_q} + (FCW+1)'(1)) < {1'b0, nf_q};
  assign done_go = !out_valid_q || rsp.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req.valid) state_d = S_SCAN;
      S_SCAN: begin
        if (op_q == OP_ALLOC) begin
          if (f_end) state_d = S_DONE;
          else if (f_fit[fi_q[FIW-1:0]]) begin
            state_d = (nu_q >= UCW'(USED_ENTRIES)) ? S_DONE : S_REMOVE;
          end
        end else begin
          if (u_end) state_d = S_DONE;
          else if (u_match[ui_q[UIW-1:0]]) begin
            state_d = (nf_q >= FCW'(FREE_ENTRIES)) ? S_DONE : S_REMOVE;
          end
        end
      end
      S_REMOVE: begin
        if (op_q == OP_FREE) state_d = S_FPLACE;
        else state_d = (nl_q != '0) ? S_FPLACE : S_UPLACE;
      end
      S_FPLACE:  if (f_place) state_d = S_FINSERT;
      S_FINSERT: state_d = (op_q == OP_FREE) ? S_MERGE : S_UPLACE;
      S_UPLACE:  if (u_place) state_d = S_UINSERT;
      S_UINSERT: state_d = S_DONE;
      S_MERGE:   if (!merge_more) state_d = S_DONE;
      S_DONE:    if (done_go) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Table commands and the request-side ready.
  always_comb begin
    fcmd = '{op: T_NONE, start: '0, size: '0};
    ucmd = '{op: T_NONE, start: '0, size: '0};
    in_ready = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (cfg_hit) begin
          fcmd = '{op: T_INIT, start: cfg_base, size: cfg_len};
          ucmd.op = T_CLEAR;
        end
      end
      S_REMOVE: begin
        if (op_q == OP_ALLOC) fcmd.op = T_REMOVE;
        else ucmd.op = T_REMOVE;
      end
      S_FINSERT: fcmd = '{op: T_INSERT, start: f_key,
                          size: (op_q == OP_FREE) ? req_q : nl_q};
      S_UINSERT: ucmd = '{op: T_INSERT, start: b_q, size: req_q};
      S_MERGE:   if (merge_more && f_adj[fi_q[FIW-1:0]]) fcmd.op = T_MERGE;
      default: ;
    endcase
  end

  assign req.ready = in_ready;

  ffra_table #(.DEPTH(FREE_ENTRIES)) u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fcmd),
    .idx_i       (fi_q),
    .cnt_i       (nf_q),
    .key_start_i (f_key),
    .key_size_i  (req_q),
    .rd_idx_i    (fi_q[FIW-1:0]),
    .rd_o        (frd),
    .fit_o       (f_fit),
    .match_o     (),
    .lt_o        (f_lt),
    .gt_o        (f_gt),
    .adj_o       (f_adj)
  );

  ffra_table #(.DEPTH(USED_ENTRIES)) u_used (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ucmd),
    .idx_i       (ui_q),
    .cnt_i       (nu_q),
    .key_start_i (u_key),
    .key_size_i  (req_q),
    .rd_idx_i    ('0),
    .rd_o        (),
    .fit_o       (),
    .match_o     (u_match),
    .lt_o        (u_lt),
    .gt_o        (u_gt),
    .adj_o       ()
  );

  // Control state, counts, scan indexes, pool registers, status and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nf_q        <= FCW'(1);
      nu_q        <= '0;
      fi_q        <= '0;
      ui_q        <= '0;
      out_valid_q <= 1'b0;
      pool_base_q <= '0;
      pool_len_q  <= '0;
      status_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && done_go) out_valid_q <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_hit) begin
            pool_base_q <= cfg_base;
            pool_len_q  <= cfg_len;
            nf_q        <= FCW'(1);
            nu_q        <= '0;
          end
          fi_q     <= '0;
          ui_q     <= '0;
          status_q <= ST_OK;
        end
        S_SCAN: begin
          if (op_q == OP_ALLOC) begin
            if (f_end) status_q <= ST_OOM;
            else if (f_fit[fi_q[FIW-1:0]]) begin
              if (nu_q >= UCW'(USED_ENTRIES)) status_q <= ST_TABLE_FULL;
            end else fi_q <= fi_q + FCW'(1);
          end else begin
            if (u_end) status_q <= ST_NOT_FOUND;
            else if (u_match[ui_q[UIW-1:0]]) begin
              if (nf_q >= FCW'(FREE_ENTRIES)) status_q <= ST_TABLE_FULL;
            end else ui_q <= ui_q + UCW'(1);
          end
        end
        S_REMOVE: begin
          if (op_q == OP_ALLOC) nf_q <= nf_q - FCW'(1);
          else nu_q <= nu_q - UCW'(1);
          fi_q <= '0;
          ui_q <= '0;
        end
        S_FPLACE: if (!f_place) fi_q <= fi_q + FCW'(1);
        S_FINSERT: begin
          nf_q <= nf_q + FCW'(1);
          fi_q <= '0;
        end
        S_UPLACE: if (!u_place) ui_q <= ui_q + UCW'(1);
        S_UINSERT: nu_q <= nu_q + UCW'(1);
        S_MERGE: begin
          if (merge_more) begin
            if (f_adj[fi_q[FIW-1:0]]) nf_q <= nf_q - FCW'(1);
            else fi_q <= fi_q + FCW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Request payload, scan captures and result register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req.valid) begin
      op_q  <= req.op;
      req_q <= req.req_size;
      fb_q  <= req.free_base;
    end
    if (state_q == S_SCAN) begin
      b_q  <= frd.start;
      nb_q <= frd.start + req_q;
      nl_q <= frd.size - req_q;
    end
    if (state_q == S_DONE && done_go) begin
      out_status_q <= status_q;
      out_addr_q   <= (op_q == OP_ALLOC && status_q == ST_OK) ? b_q : '0;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.alloc_addr = out_addr_q;
  assign rsp.status     = out_status_q;

endmodule
`default_nettype wire

>>> rtl/ffra_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ffra_cell import ffra_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cell_cmd_e   cmd_i,
  input  wire entry_t      left_i,
  input  wire entry_t      right_i,
  input  wire logic [31:0] ld_start_i,
  input  wire logic [31:0] ld_size_i,
  input  wire logic [31:0] key_start_i,
  input  wire logic [31:0] key_size_i,
  output entry_t           entry_o,
  output cell_flags_t      flags_o
);

  entry_t entry_q, entry_d;

  // Local compares against the broadcast key and the right neighbor.
  always_comb begin
    flags_o.fit   = entry_q.size >= key_size_i;
    flags_o.match = (entry_q.start == key_start_i) && (entry_q.size == key_size_i);
    flags_o.lt    = entry_q.start < key_start_i;
    flags_o.gt    = entry_q.start > key_start_i;
    flags_o.adj   = (entry_q.start + entry_q.size) == right_i.start;
  end

  // Next entry from the command.
  always_comb begin
    entry_d = entry_q;
    case (cmd_i)
      C_HOLD:   entry_d = entry_q;
      C_TAKE_L: entry_d = left_i;
      C_TAKE_R: entry_d = right_i;
      C_LOAD:   entry_d = '{valid: 1'b1, start: ld_start_i, size: ld_size_i};
      C_ADD_R:  entry_d.size = entry_q.size + right_i.size;
      C_CLEAR:  entry_d = '0;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

>>> rtl/ffra_table.sv
`timescale 1ns / 1ps
`default_nettype none
module ffra_table import ffra_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tbl_cmd_t      cmd_i,
  input  wire logic [CW-1:0] idx_i,
  input  wire logic [CW-1:0] cnt_i,
  input  wire logic [31:0]   key_start_i,
  input  wire logic [31:0]   key_size_i,
  input  wire logic [IW-1:0] rd_idx_i,
  output entry_t             rd_o,
  output logic [DEPTH-1:0]   fit_o,
  output logic [DEPTH-1:0]   match_o,
  output logic [DEPTH-1:0]   lt_o,
  output logic [DEPTH-1:0]   gt_o,
  output logic [DEPTH-1:0]   adj_o
);

  entry_t entries [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    localparam logic [CW-1:0] J  = CW'(j);
    localparam logic [CW-1:0] J1 = CW'(j + 1);

    cell_cmd_e   cmd;
    entry_t      left_e, right_e;
    cell_flags_t flags;

    if (j == 0) begin : g_l0
      assign left_e = '0;
    end else begin : g_l
      assign left_e = entries[j-1];
    end
    if (j == DEPTH - 1) begin : g_rn
      assign right_e = '0;
    end else begin : g_r
      assign right_e = entries[j+1];
    end

    // Decode the table command into this cell's role.
    always_comb begin
      cmd = C_HOLD;
      case (cmd_i.op)
        T_REMOVE: begin
          if (J == cnt_i - CW'(1)) cmd = C_CLEAR;
          else if (J >= idx_i && J1 < cnt_i) cmd = C_TAKE_R;
        end
        T_INSERT: begin
          if (J == idx_i) cmd = C_LOAD;
          else if (J > idx_i && J <= cnt_i) cmd = C_TAKE_L;
        end
        T_MERGE: begin
          if (J == idx_i) cmd = C_ADD_R;
          else if (J == cnt_i - CW'(1)) cmd = C_CLEAR;
          else if (J > idx_i && J1 < cnt_i) cmd = C_TAKE_R;
        end
        T_INIT:  cmd = (j == 0) ? C_LOAD : C_CLEAR;
        T_CLEAR: cmd = C_CLEAR;
        default: cmd = C_HOLD;
      endcase
    end

    ffra_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_e),
      .right_i     (right_e),
      .ld_start_i  (cmd_i.start),
      .ld_size_i   (cmd_i.size),
      .key_start_i (key_start_i),
      .key_size_i  (key_size_i),
      .entry_o     (entries[j]),
      .flags_o     (flags)
    );

    assign fit_o[j]   = flags.fit;
    assign match_o[j] = flags.match;
    assign lt_o[j]    = flags.lt;
    assign gt_o[j]    = flags.gt;
    assign adj_o[j]   = flags.adj;
  end

  assign rd_o = entries[rd_idx_i];

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ffra_pkg::*;

  localparam int NFREE = 16;
  localparam int NUSED = 16;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct {
    logic [31:0] addr;
    status_e     status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  ffra_req_if req_ch ();
  ffra_rsp_if rsp_ch ();

  first_fit_region_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch.sink),
    .rsp        (rsp_ch.source)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the allocator tables and pool registers.
  logic [31:0] pool_base_q, pool_len_q;
  logic [31:0] fr_start[NFREE];
  logic [31:0] fr_size[NFREE];
  int          fr_cnt;
  logic [31:0] ur_start[NUSED];
  logic [31:0] ur_size[NUSED];
  int          ur_cnt;

  outcome_t expected_q[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  rsp_stall = 0;
  bit  idle_enabled = 1'b1;

  // Live allocations known to the stimulus, so that frees can hit them.
  logic [31:0] live_base[$];
  logic [31:0] live_size[$];

  function automatic void reset_tables();
    fr_cnt = 1;
    fr_start[0] = pool_base_q;
    fr_size[0] = pool_len_q;
    ur_cnt = 0;
  endfunction

  // Sorted insert; an equal start to entry 0 lands at index 1.
  function automatic void free_insert(logic [31:0] b, logic [31:0] len);
    int p;
    p = 0;
    if (fr_cnt > 0 && b >= fr_start[0]) begin
      p = 1;
      while (p < fr_cnt && fr_start[p] < b) p++;
    end
    for (int i = fr_cnt; i > p; i--) begin
      fr_start[i] = fr_start[i-1];
      fr_size[i] = fr_size[i-1];
    end
    fr_start[p] = b;
    fr_size[p] = len;
    fr_cnt++;
  endfunction

  function automatic void used_insert(logic [31:0] b, logic [31:0] len);
    int p;
    p = 0;
    if (ur_cnt > 0 && b >= ur_start[0]) begin
      p = 1;
      while (p < ur_cnt && ur_start[p] < b) p++;
    end
    for (int i = ur_cnt; i > p; i--) begin
      ur_start[i] = ur_start[i-1];
      ur_size[i] = ur_size[i-1];
    end
    ur_start[p] = b;
    ur_size[p] = len;
    ur_cnt++;
  endfunction

  function automatic void free_remove(int k);
    for (int i = k; i + 1 < fr_cnt; i++) begin
      fr_start[i] = fr_start[i+1];
      fr_size[i] = fr_size[i+1];
    end
    fr_cnt--;
  endfunction

  function automatic void used_remove(int k);
    for (int i = k; i + 1 < ur_cnt; i++) begin
      ur_start[i] = ur_start[i+1];
      ur_size[i] = ur_size[i+1];
    end
    ur_cnt--;
  endfunction

  // Computes the outcome of one request and updates the shadow tables.
  function automatic outcome_t predict_request(op_e op, logic [31:0] sz, logic [31:0] fb);
    outcome_t r;
    int k;
    logic [31:0] b, rest;
    r.addr = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      k = 0;
      while (k < fr_cnt && fr_size[k] < sz) k++;
      if (k >= fr_cnt) r.status = ST_OOM;
      else if (ur_cnt >= NUSED) r.status = ST_TABLE_FULL;
      else begin
        b = fr_start[k];
        rest = fr_size[k] - sz;
        free_remove(k);
        if (rest != 0) free_insert(b + sz, rest);
        used_insert(b, sz);
        r.addr = b;
      end
    end else begin
      k = 0;
      while (k < ur_cnt && !(ur_start[k] == fb && ur_size[k] == sz)) k++;
      if (k >= ur_cnt) r.status = ST_NOT_FOUND;
      else if (fr_cnt >= NFREE) r.status = ST_TABLE_FULL;
      else begin
        used_remove(k);
        free_insert(fb, sz);
        k = 0;
        while (k + 1 < fr_cnt) begin
          if (fr_start[k] + fr_size[k] == fr_start[k+1]) begin
            fr_size[k] = fr_size[k] + fr_size[k+1];
            free_remove(k + 1);
          end else k++;
        end
      end
    end
    return r;
  endfunction

  // Waits a random idle burst when idling is on, with valid dropped.
  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Sends one request transaction and records its expected outcome.
  // Valid stays high after the accept so that items can follow back to back.
  task automatic send_request(op_e op, logic [31:0] sz, logic [31:0] fb);
    outcome_t r;
    maybe_idle();
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.req_size <= sz;
    req_ch.free_base <= fb;
    do @(posedge clk_i); while (!req_ch.ready);
    r = predict_request(op, sz, fb);
    expected_q.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) begin
      live_base.push_back(r.addr);
      live_size.push_back(sz);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Writes one pool register while the block is idle.
  task automatic write_config(cfg_idx_e idx, logic [31:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POOL_BASE) pool_base_q = val;
    else pool_len_q = val;
    reset_tables();
    live_base.delete();
    live_size.delete();
  endtask

  // Frees a random live allocation and forgets it.
  task automatic free_live();
    int k;
    k = $urandom_range(0, live_base.size() - 1);
    send_request(OP_FREE, live_size[k], live_base[k]);
    live_base.delete(k);
    live_size.delete(k);
  endtask

  // Response sink with random stall bursts, comparing against the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result addr=%h status=%0d", rsp_ch.alloc_addr, rsp_ch.status);
        error_count++;
      end else begin
        e = expected_q.pop_front();
        if (rsp_ch.alloc_addr !== e.addr) begin
          $error("alloc_addr expected %h actual %h", e.addr, rsp_ch.alloc_addr);
          error_count++;
        end
        if (rsp_ch.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp_ch.status);
          error_count++;
        end
      end
    end
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= 1'b0;
    end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
      rsp_stall = $urandom_range(0, 4);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Extremes of the fields and the out-of-memory and not-found cases.
  task automatic test_directed();
    send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_FREE, 32'd5, 32'd5);
    write_config(CFG_POOL_BASE, 32'h0000_1000);
    write_config(CFG_POOL_LENGTH, 32'h0000_0100);
    send_request(OP_ALLOC, 32'h0000_0040, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'd0, 32'd0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_ALLOC, 32'h0000_00C0, 32'd0);
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'd0);
    send_request(OP_FREE, 32'h0000_0040, 32'h0000_1000);
    send_request(OP_FREE, 32'h0000_0040, 32'h0000_1000);
    send_request(OP_FREE, 32'd0, 32'h0000_1040);
    send_request(OP_FREE, 32'h0000_00C0, 32'h0000_1040);
    // Pool wrapping past the top of the address space.
    write_config(CFG_POOL_BASE, 32'hFFFF_FFF0);
    send_request(OP_ALLOC, 32'h0000_0010, 32'd0);
    send_request(OP_ALLOC, 32'h0000_0020, 32'd0);
    send_request(OP_FREE, 32'h0000_0010, 32'hFFFF_FFF0);
    write_config(CFG_POOL_LENGTH, 32'hFFFF_FFFF);
    write_config(CFG_POOL_BASE, 32'd0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
  endtask

  // Fills the used table, then fragments the free table with non-adjacent frees.
  task automatic test_table_full();
    write_config(CFG_POOL_LENGTH, 32'd4096);
    for (int i = 0; i < 17; i++) send_request(OP_ALLOC, 32'd16, 32'd0);
    for (int i = 0; i < 16; i += 2) send_request(OP_FREE, 32'd16, 32'(i * 16));
    send_request(OP_ALLOC, 32'd3, 32'd0);
    send_request(OP_ALLOC, 32'd3, 32'd0);
    for (int i = 0; i < 4; i++) free_live();
  endtask

  // Mostly well-formed alloc/free traffic across several pool settings.
  task automatic test_random(int n);
    int sel;
    logic [31:0] sz;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        write_config(CFG_POOL_BASE, $urandom());
        write_config(CFG_POOL_LENGTH, (i % 400 == 0) ? $urandom() : $urandom_range(16, 2048));
      end
      if (i == 600) wait_drained();
      if (i == 800) idle_enabled = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 3))
          0: sz = 32'd0;
          1: sz = $urandom();
          default: sz = $urandom_range(1, 300);
        endcase
        send_request(OP_ALLOC, sz, $urandom());
      end else if (sel < 85 && live_base.size() != 0) free_live();
      else if (sel < 92 && live_base.size() != 0)
        send_request(OP_FREE, live_size[0] + 32'd1, live_base[0]);
      else send_request(op_e'($urandom_range(0, 1)), $urandom(), $urandom());
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.req_size = '0;
    req_ch.free_base = '0;
    pool_base_q = '0;
    pool_len_q = '0;
    reset_tables();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (40) @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(900);
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
